@@ design/pbod_pkg.sv @@
// ----------------------------------------------------------------------------
// pbod_pkg
// Shared constants and types for the pairwise box overlap detector.
// ----------------------------------------------------------------------------
package pbod_pkg;

    localparam int MAX_BOXES_DEF  = 32;
    localparam int COORD_BITS_DEF = 16;

    // result index fields are fixed at 5 bits (slot numbers from 32 up wrap)
    localparam int IDX_OUT_W      = 5;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_flags;

endpackage

@@ design/pairwise_box_overlap_detector_unit.sv @@
// Results: after an item leaves the queue, a pair result is registered out once the
// next overlap of the sweep is found (the last pair once the sweep of the store ends).
// The back end takes no new item until the sweep is done and the new box is stored;
// the sweep reads the store RAM one stored box per cycle; a full store drops the item.
// Reset: synchronous, active low; clears the box count and the queue.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// pairwise_box_overlap_detector_unit
// 2-D axis-aligned box overlap test against all boxes stored in the frame.
// ----------------------------------------------------------------------------
module pairwise_box_overlap_detector_unit #(
    parameter int MAX_BOXES  = pbod_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = pbod_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_BITS-1:0]         i_obj_x,
    input  logic signed [COORD_BITS-1:0]         i_obj_y,
    input  logic signed [COORD_BITS-1:0]         i_off_x,
    input  logic signed [COORD_BITS-1:0]         i_off_y,
    input  logic        [COORD_BITS-1:0]         i_box_width,
    input  logic        [COORD_BITS-1:0]         i_box_height,
    input  logic                                 i_frame_end,
    output logic                                 o_strobe,
    output logic [pbod_pkg::IDX_OUT_W-1:0]       o_earlier_index,
    output logic [pbod_pkg::IDX_OUT_W-1:0]       o_new_index,
    output logic                                 o_last_pair
);

    localparam int QW = 4 * (COORD_BITS + 3) + 1;

    pbod_pkg::t_q_flags q_flags;
    logic               q_push, q_pop;
    logic [QW-1:0]      q_wdata, q_rdata;

    pbod_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_obj_x      (i_obj_x),
        .i_obj_y      (i_obj_y),
        .i_off_x      (i_off_x),
        .i_off_y      (i_off_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_frame_end  (i_frame_end),
        .i_q_flags    (q_flags),
        .o_push       (q_push),
        .o_push_data  (q_wdata)
    );

    pbod_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_flags (q_flags)
    );

    pbod_back #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_flags       (q_flags),
        .i_q_data        (q_rdata),
        .o_pop           (q_pop),
        .o_strobe        (o_strobe),
        .o_earlier_index (o_earlier_index),
        .o_new_index     (o_new_index),
        .o_last_pair     (o_last_pair)
    );

endmodule

@@ design/pbod_ram.sv @@
// ----------------------------------------------------------------------------
// pbod_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module pbod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/pbod_front.sv @@
// ----------------------------------------------------------------------------
// pbod_front
// Accepts box items, forms the doubled-scale box edges and queues them.
// ----------------------------------------------------------------------------
module pbod_front #(
    parameter int COORD_BITS = pbod_pkg::COORD_BITS_DEF,
    localparam int E = COORD_BITS + 3,
    localparam int QW = 4 * E + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_obj_x,
    input  logic signed [COORD_BITS-1:0] i_obj_y,
    input  logic signed [COORD_BITS-1:0] i_off_x,
    input  logic signed [COORD_BITS-1:0] i_off_y,
    input  logic        [COORD_BITS-1:0] i_box_width,
    input  logic        [COORD_BITS-1:0] i_box_height,
    input  logic                         i_frame_end,
    input  pbod_pkg::t_q_flags           i_q_flags,
    output logic                         o_push,
    output logic [QW-1:0]                o_push_data
);

    localparam int CW = COORD_BITS + 1;

    logic                         r_vld;
    logic signed [COORD_BITS-1:0] r_obj_x, r_obj_y, r_off_x, r_off_y;
    logic        [COORD_BITS-1:0] r_w, r_h;
    logic                         r_fe;

    logic                accept;
    logic signed [CW-1:0] w_cx, w_cy;
    logic signed [E-1:0]  w_dx, w_dy, w_wx, w_wy;
    logic signed [E-1:0]  w_lo_x, w_hi_x, w_lo_y, w_hi_y;

    assign o_push = r_vld && !i_q_flags.full;
    assign busy   = r_vld && i_q_flags.full;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_obj_x <= i_obj_x;
            r_obj_y <= i_obj_y;
            r_off_x <= i_off_x;
            r_off_y <= i_off_y;
            r_w     <= i_box_width;
            r_h     <= i_box_height;
            r_fe    <= i_frame_end;
        end
    end

    // edges at doubled scale: 2c - w and 2c + w, exact
    always_comb begin
        w_cx   = CW'(r_obj_x) + CW'(r_off_x);
        w_cy   = CW'(r_obj_y) + CW'(r_off_y);
        w_dx   = E'(w_cx) <<< 1;
        w_dy   = E'(w_cy) <<< 1;
        w_wx   = $signed(E'(r_w));
        w_wy   = $signed(E'(r_h));
        w_lo_x = w_dx - w_wx;
        w_hi_x = w_dx + w_wx;
        w_lo_y = w_dy - w_wy;
        w_hi_y = w_dy + w_wy;
    end

    assign o_push_data = {w_lo_x, w_hi_x, w_lo_y, w_hi_y, r_fe};

endmodule

@@ design/pbod_queue.sv @@
// ----------------------------------------------------------------------------
// pbod_queue
// Short FIFO of box edge items between front and back.
// ----------------------------------------------------------------------------
module pbod_queue #(
    parameter int WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output pbod_pkg::t_q_flags o_flags
);

    localparam int DEPTH = pbod_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [NW-1:0]    r_n, n_n;

    assign o_flags.empty = (r_n == '0);
    assign o_flags.full  = (r_n == NW'(DEPTH));
    assign o_data        = r_mem[r_rp];

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        n_n  = r_n;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_n = r_n + NW'(1);
            2'b01:   n_n = r_n - NW'(1);
            default: n_n = r_n;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_n  <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_n  <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_flags.full || i_pop))
        else $error("queue push while full");

endmodule

@@ design/pbod_back.sv @@
// ----------------------------------------------------------------------------
// pbod_back
// Sweeps the stored boxes of the frame against the new one, emits the pairs
// and stores the new box.
// ----------------------------------------------------------------------------
module pbod_back #(
    parameter int MAX_BOXES  = pbod_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = pbod_pkg::COORD_BITS_DEF,
    localparam int E  = COORD_BITS + 3,
    localparam int QW = 4 * E + 1,
    localparam int OW = pbod_pkg::IDX_OUT_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pbod_pkg::t_q_flags i_q_flags,
    input  logic [QW-1:0]      i_q_data,
    output logic               o_pop,
    output logic               o_strobe,
    output logic [OW-1:0]      o_earlier_index,
    output logic [OW-1:0]      o_new_index,
    output logic               o_last_pair
);

    localparam int IW   = $clog2(MAX_BOXES);
    localparam int CNTW = $clog2(MAX_BOXES + 1);
    localparam int RW   = 4 * E;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_count, n_count;
    logic [CNTW-1:0] r_rd_idx, n_rd_idx;
    logic            r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]   r_cmp_idx, n_cmp_idx;
    logic            r_pend_vld, n_pend_vld;
    logic [IW-1:0]   r_pend_idx, n_pend_idx;
    logic [QW-1:0]   r_cmd, n_cmd;
    logic            r_strobe, n_strobe;
    logic            r_last, n_last;
    logic [IW-1:0]   r_ear, n_ear;
    logic [IW-1:0]   r_new, n_new;

    logic            ram_we, ram_re;
    logic [IW-1:0]   ram_addr;
    logic [RW-1:0]   ram_rdata;

    logic signed [E-1:0] a_lo_x, a_hi_x, a_lo_y, a_hi_y;
    logic signed [E-1:0] b_lo_x, b_hi_x, b_lo_y, b_hi_y;
    logic                b_fe;
    logic                w_hit;

    assign {a_lo_x, a_hi_x, a_lo_y, a_hi_y}       = ram_rdata;
    assign {b_lo_x, b_hi_x, b_lo_y, b_hi_y, b_fe} = r_cmd;

    // strict overlap on both axes
    assign w_hit = (a_lo_x < b_hi_x) && (a_hi_x > b_lo_x) &&
                   (a_lo_y < b_hi_y) && (a_hi_y > b_lo_y);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_cmd      = r_cmd;
        n_strobe   = 1'b0;
        n_last     = 1'b0;
        n_ear      = r_ear;
        n_new      = r_new;
        o_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_flags.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_q_data;
                    if (r_count == CNTW'(MAX_BOXES)) begin
                        // store full: item ignored, frame end still clears
                        if (i_q_data[0]) begin
                            n_count = '0;
                        end
                    end else begin
                        n_state    = S_SCAN;
                        n_rd_idx   = '0;
                        n_cmp_vld  = 1'b0;
                        n_pend_vld = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                // a hit is held back until the next one is found so the last one can be flagged
                if (r_cmp_vld && w_hit) begin
                    if (r_pend_vld) begin
                        n_strobe = 1'b1;
                        n_ear    = r_pend_idx;
                        n_new    = r_count[IW-1:0];
                    end
                    n_pend_vld = 1'b1;
                    n_pend_idx = r_cmp_idx;
                end
                if (r_rd_idx != r_count) begin
                    ram_re    = 1'b1;
                    n_rd_idx  = r_rd_idx + CNTW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx[IW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                    if (!r_cmp_vld) begin
                        if (r_pend_vld) begin
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                            n_ear    = r_pend_idx;
                            n_new    = r_count[IW-1:0];
                        end
                        ram_we  = 1'b1;
                        n_count = b_fe ? '0 : r_count + CNTW'(1);
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign ram_addr = ram_we ? r_count[IW-1:0] : r_rd_idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_idx   <= n_rd_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_pend_idx <= n_pend_idx;
        r_cmd      <= n_cmd;
        r_last     <= n_last;
        r_ear      <= n_ear;
        r_new      <= n_new;
    end

    pbod_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_cmd[QW-1:1]),
        .o_rdata (ram_rdata)
    );

    assign o_strobe        = r_strobe;
    assign o_last_pair     = r_last;
    assign o_earlier_index = OW'(r_ear);
    assign o_new_index     = OW'(r_new);

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (CNTW'(r_cmp_idx) < r_count))
        else $error("compare slot beyond stored boxes");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_BOXES))
        else $error("box count over capacity");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |=> !r_strobe)
        else $error("result after last pair of item");

    a_write_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_count < CNTW'(MAX_BOXES)))
        else $error("store write with store full");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Sends boxes to the pairwise box overlap detector and checks every pair
// result, in order, against a predictor that keeps its own box store: edge
// cases first, then a full store, then random frames of clustered boxes with
// noise, random start gaps and gapless runs.
// ----------------------------------------------------------------------------
module testbench;

    localparam int BOX_CAP      = pbod_pkg::MAX_BOXES_DEF;
    localparam int COORD_W      = pbod_pkg::COORD_BITS_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 60;

    typedef logic [pbod_pkg::IDX_OUT_W-1:0] t_idx;

    typedef struct packed {
        t_idx earlier;
        t_idx newer;
        logic last;
    } t_pair;

    typedef struct packed {
        logic [COORD_W-1:0] obj_x;
        logic [COORD_W-1:0] obj_y;
        logic [COORD_W-1:0] off_x;
        logic [COORD_W-1:0] off_y;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic               frame_end;
    } t_box;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [COORD_W-1:0]  i_obj_x;
    logic [COORD_W-1:0]  i_obj_y;
    logic [COORD_W-1:0]  i_off_x;
    logic [COORD_W-1:0]  i_off_y;
    logic [COORD_W-1:0]  i_box_width;
    logic [COORD_W-1:0]  i_box_height;
    logic                i_frame_end;
    logic                o_strobe;
    t_idx                o_earlier_index;
    t_idx                o_new_index;
    logic                o_last_pair;

    // predictor copy of the box store
    longint  stored_cx[BOX_CAP];
    longint  stored_cy[BOX_CAP];
    longint  stored_w[BOX_CAP];
    longint  stored_h[BOX_CAP];
    int      stored_count;

    t_pair   expected_pairs[$];
    int      mismatches;
    int      pairs_checked;
    int      boxes_sent;
    int      frames_sent;
    int      boxes_dropped;
    int      cycle_count;
    bit      gapless;

    pairwise_box_overlap_detector_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_obj_x         (i_obj_x),
        .i_obj_y         (i_obj_y),
        .i_off_x         (i_off_x),
        .i_off_y         (i_off_y),
        .i_box_width     (i_box_width),
        .i_box_height    (i_box_height),
        .i_frame_end     (i_frame_end),
        .o_strobe        (o_strobe),
        .o_earlier_index (o_earlier_index),
        .o_new_index     (o_new_index),
        .o_last_pair     (o_last_pair)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // strict overlap on one axis, at doubled scale so half extents stay exact
    function automatic bit spans_overlap(longint ca, longint wa, longint cb, longint wb);
        return (2 * ca - wa < 2 * cb + wb) && (2 * ca + wa > 2 * cb - wb);
    endfunction

    task automatic predict_pairs(input t_box b);
        longint cx;
        longint cy;
        int     hits[$];
        t_pair  p;
        if (stored_count < BOX_CAP) begin
            cx = longint'($signed(b.obj_x)) + longint'($signed(b.off_x));
            cy = longint'($signed(b.obj_y)) + longint'($signed(b.off_y));
            for (int i = 0; i < stored_count; i++) begin
                if (spans_overlap(stored_cx[i], stored_w[i], cx, longint'(b.width)) &&
                    spans_overlap(stored_cy[i], stored_h[i], cy, longint'(b.height)))
                    hits = {hits, i};
            end
            foreach (hits[k]) begin
                p.earlier = t_idx'(hits[k]);
                p.newer   = t_idx'(stored_count);
                p.last    = (k == hits.size() - 1);
                expected_pairs = {expected_pairs, p};
            end
            stored_cx[stored_count] = cx;
            stored_cy[stored_count] = cy;
            stored_w[stored_count]  = longint'(b.width);
            stored_h[stored_count]  = longint'(b.height);
            stored_count++;
        end else begin
            boxes_dropped++;
        end
        if (b.frame_end)
            stored_count = 0;
    endtask

    always @(posedge i_clk) begin : check_pairs
        t_pair want;
        if (i_rst_n && o_strobe) begin
            if (expected_pairs.size() == 0) begin
                $error("unexpected pair result: earlier_index %0d new_index %0d last_pair %0b",
                       o_earlier_index, o_new_index, o_last_pair);
                mismatches++;
            end else begin
                want = expected_pairs.pop_front();
                pairs_checked++;
                if (o_earlier_index !== want.earlier) begin
                    $error("earlier_index: expected %0d, got %0d", want.earlier,
                           o_earlier_index);
                    mismatches++;
                end
                if (o_new_index !== want.newer) begin
                    $error("new_index: expected %0d, got %0d", want.newer, o_new_index);
                    mismatches++;
                end
                if (o_last_pair !== want.last) begin
                    $error("last_pair: expected %0b, got %0b", want.last, o_last_pair);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_box(input t_box b);
        @(negedge i_clk);
        i_obj_x      <= b.obj_x;
        i_obj_y      <= b.obj_y;
        i_off_x      <= b.off_x;
        i_off_y      <= b.off_y;
        i_box_width  <= b.width;
        i_box_height <= b.height;
        i_frame_end  <= b.frame_end;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_pairs(b);
        boxes_sent++;
        if (b.frame_end)
            frames_sent++;
    endtask

    // mostly back to back or short gaps, now and then a long one
    task automatic idle_after;
        int gap;
        int r;
        r = $urandom_range(0, 9);
        if (gapless || r < 5)
            gap = 0;
        else if (r < 9)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_box make_box(int ox, int oy, int fx, int fy, int w, int h, bit fe);
        t_box b;
        b.obj_x     = ox[COORD_W-1:0];
        b.obj_y     = oy[COORD_W-1:0];
        b.off_x     = fx[COORD_W-1:0];
        b.off_y     = fy[COORD_W-1:0];
        b.width     = w[COORD_W-1:0];
        b.height    = h[COORD_W-1:0];
        b.frame_end = fe;
        return b;
    endfunction

    // random position cancelled by the offset, so centers land near the origin
    function automatic t_box cluster_box(int spread, int ext_lo, int ext_hi, bit fe);
        int ox;
        int oy;
        ox = int'($signed(16'($urandom)));
        oy = int'($signed(16'($urandom)));
        return make_box(ox, oy,
                        -ox + $urandom_range(0, 2 * spread) - spread,
                        -oy + $urandom_range(0, 2 * spread) - spread,
                        $urandom_range(ext_lo, ext_hi), $urandom_range(ext_lo, ext_hi), fe);
    endfunction

    function automatic t_box noise_box(bit fe);
        return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, fe);
    endfunction

    task automatic test_edge_cases;
        t_box plan[13];
        // boxes of extent 16: identical, touching; then zero extent at a shared center
        plan[0]  = make_box(0, 0, 0, 0, 16, 16, 0);
        plan[1]  = make_box(0, 0, 0, 0, 16, 16, 0);
        plan[2]  = make_box(0, 0, 16, 0, 16, 16, 0);
        plan[3]  = make_box(8, 8, -8, -8, 0, 0, 0);
        plan[4]  = make_box(0, 0, 0, 0, 0, 0, 1);
        // coordinate extremes; centers at both ends and edges that just meet
        plan[5]  = make_box(-32768, -32768, -32768, -32768, 65535, 65535, 0);
        plan[6]  = make_box(32767, 32767, 32767, 32767, 65535, 65535, 0);
        plan[7]  = make_box(-32768, 32767, 32767, -32768, 65535, 65535, 0);
        plan[8]  = make_box(-32768, -32768, 32767, 32767, 65535, 0, 0);
        plan[9]  = make_box(0, 0, 0, 0, 65535, 65535, 1);
        // one-box frame, then slots must restart at zero
        plan[10] = make_box(100, -100, 5, -5, 3, 3, 1);
        plan[11] = make_box(100, -100, 5, -5, 3, 3, 0);
        plan[12] = make_box(100, -100, 5, -5, 3, 3, 1);
        foreach (plan[k]) begin
            send_box(plan[k]);
            idle_after();
        end
    endtask

    // tight cluster fills every slot; the extra boxes must be dropped
    task automatic test_store_full;
        for (int k = 0; k < BOX_CAP + 3; k++) begin
            gapless = (k >= 8 && k < 20);
            send_box(cluster_box(8, 32, 64, k == BOX_CAP + 2));
            idle_after();
        end
        gapless = 0;
    endtask

    task automatic test_random_frames(input int target);
        int  first;
        int  frame_len;
        int  spread;
        int  ext;
        bit  fe;
        first = boxes_sent;
        while (boxes_sent - first < target) begin
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                    : $urandom_range(1, 8);
            spread  = 16 << (3 * $urandom_range(0, 3));
            ext     = 32 << (3 * $urandom_range(0, 2));
            gapless = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < frame_len; k++) begin
                // sometimes the frame end is missing and the frame runs on
                fe = (k == frame_len - 1) && ($urandom_range(0, 7) != 0);
                if ($urandom_range(0, 5) == 0)
                    send_box(noise_box(fe));
                else
                    send_box(cluster_box(spread, 0, ext, fe));
                idle_after();
            end
        end
        gapless = 0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_obj_x      = '0;
        i_obj_y      = '0;
        i_off_x      = '0;
        i_off_y      = '0;
        i_box_width  = '0;
        i_box_height = '0;
        i_frame_end  = 1'b0;
        stored_count  = 0;
        mismatches    = 0;
        pairs_checked = 0;
        boxes_sent    = 0;
        frames_sent   = 0;
        boxes_dropped = 0;
        cycle_count   = 0;
        gapless       = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_store_full();
        test_random_frames(RANDOM_ITEMS);

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d boxes in %0d closed frames, %0d dropped on a full store",
                 boxes_sent, frames_sent, boxes_dropped);
        $display("%0d overlap pairs compared field by field", pairs_checked);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
